>>> sv/stut_pkg.sv
`timescale 1ns / 1ps

package stut_pkg;

    localparam int PADDR_W = 4;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_SEND = 2'd1;
    localparam logic [1:0] CMD_RECV = 2'd2;

    localparam logic [2:0] MODE_IDLE      = 3'd0;
    localparam logic [2:0] MODE_SEND      = 3'd1;
    localparam logic [2:0] MODE_ARMED     = 3'd2;
    localparam logic [2:0] MODE_WAIT_EDGE = 3'd3;
    localparam logic [2:0] MODE_SAMPLE    = 3'd4;

    localparam logic [3:0] PARITY_COUNT = 4'd9;
    localparam logic [3:0] STOP_COUNT   = 4'd10;

    localparam logic [1:0] REG_BIT_LENGTH    = 2'd0;
    localparam logic [1:0] REG_SEND_OFFSET   = 2'd1;
    localparam logic [1:0] REG_RECV_SETUP    = 2'd2;
    localparam logic [1:0] REG_SAMPLE_OFFSET = 2'd3;

    localparam logic [15:0] BIT_LENGTH_RESET = 16'd1000;

    typedef struct packed {
        logic [15:0] bit_length;
        logic [10:0] send_offset;
        logic [10:0] recv_setup_offset;
        logic [10:0] sample_offset;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] slot_start;
        logic [2:0]  speed_shift;
        logic [7:0]  tx_byte;
        logic        tx_parity;
        logic        timeout_enable;
        logic        rx_level;
    } t_item;

    typedef struct packed {
        logic        tx_level;
        logic        tx_drive;
        logic        done_res;
        logic        status;
        logic [7:0]  rx_byte;
        logic        rx_parity;
        logic [15:0] time_stamp;
    } t_result;

    function automatic logic [15:0] sext11(input logic [10:0] v);
        return {{5{v[10]}}, v};
    endfunction

endpackage

>>> sv/stut_cfg.sv
`timescale 1ns / 1ps

module stut_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [stut_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output stut_pkg::t_cfg               o_cfg
);
    import stut_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[PADDR_W-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_length        <= BIT_LENGTH_RESET;
            r_cfg.send_offset       <= '0;
            r_cfg.recv_setup_offset <= '0;
            r_cfg.sample_offset     <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_BIT_LENGTH:    r_cfg.bit_length        <= pwdata[15:0];
                REG_SEND_OFFSET:   r_cfg.send_offset       <= pwdata[10:0];
                REG_RECV_SETUP:    r_cfg.recv_setup_offset <= pwdata[10:0];
                REG_SAMPLE_OFFSET: r_cfg.sample_offset     <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_BIT_LENGTH:    prdata = {16'd0, r_cfg.bit_length};
            REG_SEND_OFFSET:   prdata = {21'd0, r_cfg.send_offset};
            REG_RECV_SETUP:    prdata = {21'd0, r_cfg.recv_setup_offset};
            REG_SAMPLE_OFFSET: prdata = {21'd0, r_cfg.sample_offset};
            default:           prdata = '0;
        endcase
    end

endmodule

>>> sv/stut_engine.sv
`timescale 1ns / 1ps

module stut_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  stut_pkg::t_item   i_item,
    input  stut_pkg::t_cfg    i_cfg,
    output stut_pkg::t_result o_res
);
    import stut_pkg::*;

    logic [15:0] r_timer, n_timer;
    logic [15:0] r_cmp, n_cmp;
    logic [2:0]  r_mode, n_mode;
    logic [3:0]  r_bit_count, n_bit_count;
    logic [7:0]  r_shift, n_shift;
    logic        r_held_parity, n_held_parity;
    logic        r_next_bit, n_next_bit;
    logic        r_line_out, n_line_out;
    logic [15:0] r_ebl, n_ebl;
    logic [15:0] r_edge_time, n_edge_time;
    logic        r_prev_rx, n_prev_rx;
    logic        r_to_armed, n_to_armed;

    logic        w_match;
    logic [3:0]  w_nb;
    logic [15:0] w_cmp_step;
    t_result     w_res;

    assign w_match    = (r_timer == r_cmp);
    assign w_nb       = r_bit_count + 4'd1;
    assign w_cmp_step = r_cmp + r_ebl;
    assign o_res      = w_res;

    always_comb begin
        n_timer       = r_timer + 16'd1;
        n_cmp         = r_cmp;
        n_mode        = r_mode;
        n_bit_count   = r_bit_count;
        n_shift       = r_shift;
        n_held_parity = r_held_parity;
        n_next_bit    = r_next_bit;
        n_line_out    = r_line_out;
        n_ebl         = r_ebl;
        n_edge_time   = r_edge_time;
        n_prev_rx     = i_item.rx_level;
        n_to_armed    = r_to_armed;
        w_res         = '0;

        if (i_item.command == CMD_SEND || i_item.command == CMD_RECV) begin
            n_ebl       = i_cfg.bit_length >> i_item.speed_shift;
            n_bit_count = '0;
            n_line_out  = 1'b1;
            if (i_item.command == CMD_SEND) begin
                n_shift       = i_item.tx_byte;
                n_held_parity = i_item.tx_parity;
                n_next_bit    = 1'b0;
                n_cmp         = i_item.slot_start + sext11(i_cfg.send_offset);
                n_mode        = MODE_SEND;
            end else begin
                n_to_armed = i_item.timeout_enable;
                n_cmp      = i_item.slot_start + sext11(i_cfg.recv_setup_offset);
                n_mode     = MODE_ARMED;
            end
        end else begin
            unique case (r_mode)
                MODE_SEND: begin
                    if (w_match) begin
                        n_line_out  = r_next_bit;
                        n_cmp       = w_cmp_step;
                        n_bit_count = w_nb;
                        if (w_nb < PARITY_COUNT) begin
                            n_next_bit = r_shift[0];
                            n_shift    = {1'b0, r_shift[7:1]};
                        end else if (w_nb == PARITY_COUNT) begin
                            n_next_bit = r_held_parity;
                        end else if (w_nb == STOP_COUNT) begin
                            n_next_bit = 1'b1;
                        end else begin
                            w_res.done_res   = 1'b1;
                            w_res.time_stamp = w_cmp_step + r_ebl;
                            n_mode           = MODE_IDLE;
                        end
                    end
                end
                MODE_ARMED: begin
                    if (w_match) begin
                        n_cmp  = r_cmp + {i_cfg.bit_length[14:0], 1'b0};
                        n_mode = MODE_WAIT_EDGE;
                    end
                end
                MODE_WAIT_EDGE: begin
                    if (r_prev_rx && !i_item.rx_level) begin
                        n_edge_time = r_timer;
                        n_cmp       = r_timer + r_ebl + {1'b0, r_ebl[15:1]}
                                      + sext11(i_cfg.sample_offset);
                        n_mode      = MODE_SAMPLE;
                    end else if (r_to_armed && w_match) begin
                        w_res.done_res = 1'b1;
                        w_res.status   = 1'b1;
                        n_mode         = MODE_IDLE;
                    end
                end
                MODE_SAMPLE: begin
                    if (w_match) begin
                        n_bit_count = w_nb;
                        if (w_nb < PARITY_COUNT) begin
                            n_shift = {i_item.rx_level, r_shift[7:1]};
                            n_cmp   = w_cmp_step;
                        end else begin
                            w_res.done_res   = 1'b1;
                            w_res.rx_byte    = r_shift;
                            w_res.rx_parity  = i_item.rx_level;
                            w_res.time_stamp = r_edge_time;
                            n_mode           = MODE_IDLE;
                        end
                    end
                end
                default: ;
            endcase
        end

        w_res.tx_level = n_line_out;
        w_res.tx_drive = (n_mode == MODE_SEND);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer       <= '0;
            r_cmp         <= '0;
            r_mode        <= MODE_IDLE;
            r_bit_count   <= '0;
            r_shift       <= '0;
            r_held_parity <= 1'b0;
            r_next_bit    <= 1'b1;
            r_line_out    <= 1'b1;
            r_ebl         <= '0;
            r_edge_time   <= '0;
            r_prev_rx     <= 1'b1;
            r_to_armed    <= 1'b0;
        end else if (i_step) begin
            r_timer       <= n_timer;
            r_cmp         <= n_cmp;
            r_mode        <= n_mode;
            r_bit_count   <= n_bit_count;
            r_shift       <= n_shift;
            r_held_parity <= n_held_parity;
            r_next_bit    <= n_next_bit;
            r_line_out    <= n_line_out;
            r_ebl         <= n_ebl;
            r_edge_time   <= n_edge_time;
            r_prev_rx     <= n_prev_rx;
            r_to_armed    <= n_to_armed;
        end
    end

endmodule

>>> sv/slot_timed_uart_transceiver.sv
`timescale 1ns / 1ps
// A tick transaction is registered on input and evaluated, and its result is
// registered when the output register is empty or being read.
// One tick per cycle while the output is taken; the timer/compare update is one step per tick.
// Reset (synchronous, active low): timer and compare cleared, mode idle, lines high,
// configuration back to bit_length 1000 and zero offsets, both pipeline stages empty.
module slot_timed_uart_transceiver (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [stut_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_command,
    input  logic [15:0]                  i_slot_start,
    input  logic [2:0]                   i_speed_shift,
    input  logic [7:0]                   i_tx_byte,
    input  logic                         i_tx_parity,
    input  logic                         i_timeout_enable,
    input  logic                         i_rx_level,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_tx_level,
    output logic                         o_tx_drive,
    output logic                         o_done_res,
    output logic                         o_status,
    output logic [7:0]                   o_rx_byte,
    output logic                         o_rx_parity,
    output logic [15:0]                  o_time_stamp
);
    import stut_pkg::*;

    t_cfg    w_cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_result w_res;
    t_result r_res;
    logic    r_out_valid;
    logic    w_step;

    assign w_step     = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | w_step;

    stut_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    stut_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_item  (r_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.command        <= i_command;
            r_item.slot_start     <= i_slot_start;
            r_item.speed_shift    <= i_speed_shift;
            r_item.tx_byte        <= i_tx_byte;
            r_item.tx_parity      <= i_tx_parity;
            r_item.timeout_enable <= i_timeout_enable;
            r_item.rx_level       <= i_rx_level;
        end
        if (w_step) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_tx_level   = r_res.tx_level;
    assign o_tx_drive   = r_res.tx_drive;
    assign o_done_res   = r_res.done_res;
    assign o_status     = r_res.status;
    assign o_rx_byte    = r_res.rx_byte;
    assign o_rx_parity  = r_res.rx_parity;
    assign o_time_stamp = r_res.time_stamp;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import stut_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 6;
    localparam int OP_CAP_MAX   = 250;
    localparam int RANDOM_TICKS = 300;

    typedef struct {
        logic [15:0] timer;
        logic [15:0] compare;
        logic [2:0]  mode;
        logic [3:0]  bits;
        logic [7:0]  shreg;
        logic        parity;
        logic        next_level;
        logic        line;
        logic [15:0] eff_len;
        logic [15:0] edge_at;
        logic        last_rx;
        logic        timeout_on;
    } xcvr_state_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [1:0]          i_command = CMD_TICK;
    logic [15:0]         i_slot_start = '0;
    logic [2:0]          i_speed_shift = '0;
    logic [7:0]          i_tx_byte = '0;
    logic                i_tx_parity = 1'b0;
    logic                i_timeout_enable = 1'b0;
    logic                i_rx_level = 1'b1;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic                o_tx_level;
    logic                o_tx_drive;
    logic                o_done_res;
    logic                o_status;
    logic [7:0]          o_rx_byte;
    logic                o_rx_parity;
    logic [15:0]         o_time_stamp;

    xcvr_state_t xs;
    logic [15:0] bit_len_cfg;
    logic [15:0] send_off_cfg;
    logic [15:0] arm_off_cfg;
    logic [15:0] sample_off_cfg;

    t_result     expected_lines[$];
    int          error_count = 0;
    int          checked_count = 0;
    int          items_sent = 0;
    int          sends_done = 0;
    int          recvs_done = 0;
    int          timeouts_seen = 0;
    int          config_writes = 0;

    int          burst_left = 0;
    bit          sender_idles = 1'b1;
    int          odd_cmd_pct = 0;
    int          rx_noise_pct = 0;
    int          op_cap = 0;

    bit          frame_on = 1'b0;
    logic [15:0] frame_edge = '0;
    int          frame_len = 1;
    logic [10:0] frame_bits = '1;

    int          stall_left = 0;
    int          stall_style = 0;
    int          stall_beat = 0;

    slot_timed_uart_transceiver dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_slot_start     (i_slot_start),
        .i_speed_shift    (i_speed_shift),
        .i_tx_byte        (i_tx_byte),
        .i_tx_parity      (i_tx_parity),
        .i_timeout_enable (i_timeout_enable),
        .i_rx_level       (i_rx_level),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_tx_level       (o_tx_level),
        .o_tx_drive       (o_tx_drive),
        .o_done_res       (o_done_res),
        .o_status         (o_status),
        .o_rx_byte        (o_rx_byte),
        .o_rx_parity      (o_rx_parity),
        .o_time_stamp     (o_time_stamp)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("testbench failed");
        $finish;
    end

    function automatic void reset_xcvr_model();
        bit_len_cfg    = BIT_LENGTH_RESET;
        send_off_cfg   = '0;
        arm_off_cfg    = '0;
        sample_off_cfg = '0;
        xs.timer       = '0;
        xs.compare     = '0;
        xs.mode        = MODE_IDLE;
        xs.bits        = '0;
        xs.shreg       = '0;
        xs.parity      = 1'b0;
        xs.next_level  = 1'b1;
        xs.line        = 1'b1;
        xs.eff_len     = '0;
        xs.edge_at     = '0;
        xs.last_rx     = 1'b1;
        xs.timeout_on  = 1'b0;
    endfunction

    function automatic t_result predict_tick(t_item it);
        t_result r;
        logic    hit;
        r   = '0;
        hit = (xs.timer == xs.compare);
        if (it.command == CMD_SEND || it.command == CMD_RECV) begin
            xs.eff_len = bit_len_cfg >> it.speed_shift;
            xs.bits    = '0;
            xs.line    = 1'b1;
            if (it.command == CMD_SEND) begin
                xs.shreg      = it.tx_byte;
                xs.parity     = it.tx_parity;
                xs.next_level = 1'b0;
                xs.compare    = it.slot_start + send_off_cfg;
                xs.mode       = MODE_SEND;
            end else begin
                xs.timeout_on = it.timeout_enable;
                xs.compare    = it.slot_start + arm_off_cfg;
                xs.mode       = MODE_ARMED;
            end
        end else if (xs.mode == MODE_SEND && hit) begin
            xs.line    = xs.next_level;
            xs.compare = xs.compare + xs.eff_len;
            xs.bits    = xs.bits + 4'd1;
            if (xs.bits < PARITY_COUNT) begin
                xs.next_level = xs.shreg[0];
                xs.shreg      = xs.shreg >> 1;
            end else if (xs.bits == PARITY_COUNT) begin
                xs.next_level = xs.parity;
            end else if (xs.bits == STOP_COUNT) begin
                xs.next_level = 1'b1;
            end else begin
                r.done_res   = 1'b1;
                r.time_stamp = xs.compare + xs.eff_len;
                xs.mode      = MODE_IDLE;
                sends_done++;
            end
        end else if (xs.mode == MODE_ARMED && hit) begin
            xs.compare = xs.compare + {bit_len_cfg[14:0], 1'b0};
            xs.mode    = MODE_WAIT_EDGE;
        end else if (xs.mode == MODE_WAIT_EDGE) begin
            if (xs.last_rx && !it.rx_level) begin
                xs.edge_at = xs.timer;
                xs.compare = xs.timer + xs.eff_len + (xs.eff_len >> 1) + sample_off_cfg;
                xs.mode    = MODE_SAMPLE;
            end else if (xs.timeout_on && hit) begin
                r.done_res = 1'b1;
                r.status   = 1'b1;
                xs.mode    = MODE_IDLE;
                timeouts_seen++;
            end
        end else if (xs.mode == MODE_SAMPLE && hit) begin
            xs.bits = xs.bits + 4'd1;
            if (xs.bits < PARITY_COUNT) begin
                xs.shreg   = {it.rx_level, xs.shreg[7:1]};
                xs.compare = xs.compare + xs.eff_len;
            end else begin
                r.done_res   = 1'b1;
                r.rx_byte    = xs.shreg;
                r.rx_parity  = it.rx_level;
                r.time_stamp = xs.edge_at;
                xs.mode      = MODE_IDLE;
                recvs_done++;
            end
        end
        xs.last_rx  = it.rx_level;
        xs.timer    = xs.timer + 16'd1;
        r.tx_level  = xs.line;
        r.tx_drive  = (xs.mode == MODE_SEND);
        return r;
    endfunction

    function automatic logic line_level(logic [15:0] t);
        logic [15:0] d;
        int          idx;
        logic        lvl;
        d   = t - frame_edge;
        lvl = 1'b1;
        if (frame_on && d < 16'h8000) begin
            idx = int'(d) / frame_len;
            if (idx <= 10) lvl = frame_bits[idx];
        end
        if ($urandom_range(0, 99) < rx_noise_pct) lvl = !lvl;
        return lvl;
    endfunction

    function automatic t_item plain_tick();
        t_item it;
        it.command        = ($urandom_range(0, 99) < odd_cmd_pct) ? CMD_UNUSED : CMD_TICK;
        it.slot_start     = 16'($urandom);
        it.speed_shift    = 3'($urandom);
        it.tx_byte        = 8'($urandom);
        it.tx_parity      = 1'($urandom);
        it.timeout_enable = 1'($urandom);
        it.rx_level       = line_level(xs.timer);
        return it;
    endfunction

    task automatic send_tick(t_item it);
        int gap;
        if (burst_left == 0) begin
            gap = sender_idles ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_in_valid       <= 1'b1;
        i_command        <= it.command;
        i_slot_start     <= it.slot_start;
        i_speed_shift    <= it.speed_shift;
        i_tx_byte        <= it.tx_byte;
        i_tx_parity      <= it.tx_parity;
        i_timeout_enable <= it.timeout_enable;
        i_rx_level       <= it.rx_level;
        do @(posedge i_clk); while (!o_in_ready);
        expected_lines.push_back(predict_tick(it));
        items_sent++;
    endtask

    task automatic run_ticks(int n, bit until_idle);
        for (int i = 0; i < n; i++) begin
            if (until_idle && xs.mode == MODE_IDLE) break;
            send_tick(plain_tick());
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_lines.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (idx == REG_BIT_LENGTH) ? {16'd0, val} : {21'd0, val[10:0]};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BIT_LENGTH:  bit_len_cfg    = val;
            REG_SEND_OFFSET: send_off_cfg   = {{5{val[10]}}, val[10:0]};
            REG_RECV_SETUP:  arm_off_cfg    = {{5{val[10]}}, val[10:0]};
            default:         sample_off_cfg = {{5{val[10]}}, val[10:0]};
        endcase
        config_writes++;
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [15:0] bl, logic [15:0] snd, logic [15:0] arm,
                              logic [15:0] smp);
        settle();
        write_reg(REG_BIT_LENGTH, bl);
        write_reg(REG_SEND_OFFSET, snd);
        write_reg(REG_RECV_SETUP, arm);
        write_reg(REG_SAMPLE_OFFSET, smp);
    endtask

    task automatic start_send(int lead, logic [2:0] shift, logic [7:0] data, logic par);
        t_item it;
        it             = plain_tick();
        it.command     = CMD_SEND;
        it.slot_start  = xs.timer + 16'(lead) - send_off_cfg;
        it.speed_shift = shift;
        it.tx_byte     = data;
        it.tx_parity   = par;
        op_cap = lead + 12 * int'(bit_len_cfg >> shift) + 8;
        send_tick(it);
    endtask

    task automatic start_recv(int lead, logic [2:0] shift, logic toen, int edge_after,
                              logic [7:0] data, logic par, int skew);
        t_item       it;
        logic [15:0] arm;
        int          eff;
        int          smp;
        arm        = xs.timer + 16'(lead);
        eff        = int'(bit_len_cfg >> shift);
        smp        = int'($signed(sample_off_cfg));
        frame_on   = (edge_after >= 0);
        frame_edge = arm + 16'(edge_after);
        frame_len  = (eff + skew < 1) ? 1 : eff + skew;
        frame_bits = {1'b1, par, data, 1'b0};
        it                = plain_tick();
        it.command        = CMD_RECV;
        it.slot_start     = arm - arm_off_cfg;
        it.speed_shift    = shift;
        it.timeout_enable = toen;
        op_cap = lead + ((edge_after >= 0) ? edge_after : 2 * int'(bit_len_cfg))
                 + 12 * frame_len + ((smp < 0) ? -smp : smp) + 8;
        send_tick(it);
    endtask

    task automatic finish_op();
        run_ticks((op_cap > OP_CAP_MAX) ? OP_CAP_MAX : op_cap, 1'b1);
        frame_on = 1'b0;
    endtask

    task automatic test_send_frames();
        start_send(2, 3'd7, 8'hA5, 1'b0);
        finish_op();
        set_config(16'd16, 16'd0, 16'd0, 16'd0);
        start_send(3, 3'd2, 8'h00, 1'b0);
        finish_op();
        start_send(1, 3'd2, 8'hFF, 1'b1);
        finish_op();
        start_send(5, 3'd4, 8'h5A, 1'b1);
        finish_op();
    endtask

    task automatic test_receive_frames();
        start_recv(2, 3'd2, 1'b0, 5, 8'hA5, 1'b0, 0);
        finish_op();
        start_recv(1, 3'd1, 1'b1, 7, 8'h3C, 1'b1, 0);
        finish_op();
        start_recv(1, 3'd2, 1'b1, 9, 8'hFF, 1'b1, 0);
        finish_op();
        start_recv(3, 3'd2, 1'b0, 4, 8'h00, 1'b0, 0);
        finish_op();
        // no edge at all: timeout after two full bit lengths
        start_recv(2, 3'd2, 1'b1, -1, 8'h00, 1'b0, 0);
        finish_op();
        // edge on the very tick the timeout fires
        start_recv(2, 3'd2, 1'b1, 32, 8'h69, 1'b0, 0);
        finish_op();
        // line falls on the arming tick; only a later fall counts
        start_recv(2, 3'd2, 1'b1, 0, 8'h0F, 1'b1, 0);
        finish_op();
    endtask

    task automatic test_corner_cases();
        // slot at the current timer waits a full wrap
        start_send(0, 3'd0, 8'h81, 1'b0);
        run_ticks(20, 1'b1);
        // zero effective length: compare stops moving after the start bit
        start_send(2, 3'd7, 8'h42, 1'b1);
        run_ticks(25, 1'b1);
        start_recv(3, 3'd1, 1'b1, 6, 8'h96, 1'b0, 0);
        run_ticks(20, 1'b1);
        odd_cmd_pct = 50;
        start_send(2, 3'd2, 8'hC3, 1'b1);
        finish_op();
        odd_cmd_pct = 0;
        start_recv(2, 3'd2, 1'b0, -1, 8'h00, 1'b0, 0);
        run_ticks(60, 1'b1);
        start_recv(2, 3'd7, 1'b0, 4, 8'h11, 1'b1, 0);
        run_ticks(20, 1'b1);
        start_recv(2, 3'd2, 1'b0, 3, 8'hB2, 1'b1, 1);
        finish_op();
    endtask

    task automatic test_offset_extremes();
        set_config(16'd4, 16'h0400, 16'h03FF, 16'd0);
        start_send(3, 3'd0, 8'hFF, 1'b1);
        finish_op();
        start_recv(2, 3'd0, 1'b1, 5, 8'h5A, 1'b1, 0);
        finish_op();
        set_config(16'd4, 16'h03FF, 16'h0400, 16'h03FF);
        start_send(1, 3'd1, 8'h00, 1'b0);
        finish_op();
        start_recv(2, 3'd0, 1'b1, 3, 8'hE7, 1'b0, 0);
        run_ticks(40, 1'b1);
        set_config(16'd4, 16'h03FF, 16'h0400, 16'h0400);
        start_recv(2, 3'd0, 1'b1, 3, 8'h24, 1'b1, 0);
        run_ticks(40, 1'b1);
        set_config(16'd1, 16'h0000, 16'h03FF, 16'd0);
        start_send(1, 3'd0, 8'h96, 1'b1);
        finish_op();
        start_recv(1, 3'd0, 1'b1, 2, 8'h6B, 1'b0, 0);
        finish_op();
        set_config(16'hFFFF, 16'd0, 16'd0, 16'd0);
        start_send(1, 3'd7, 8'h55, 1'b0);
        run_ticks(60, 1'b1);
        start_recv(1, 3'd7, 1'b1, 3, 8'hAA, 1'b1, 0);
        run_ticks(60, 1'b1);
    endtask

    task automatic random_op();
        int         kind;
        int         lead;
        int         hi;
        int         e;
        int         edge_after;
        logic [2:0] shift;
        kind  = $urandom_range(0, 99);
        lead  = $urandom_range(1, 12);
        shift = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(0, 2));
        if (kind < 45) begin
            start_send(lead, shift, 8'($urandom), 1'($urandom));
        end else if (kind < 90) begin
            hi = 2 * int'(bit_len_cfg);
            if (hi > 40) hi = 40;
            if (hi < 1) hi = 1;
            e = $urandom_range(0, 9);
            edge_after = (e == 0) ? -1 : (e == 1) ? 2 * int'(bit_len_cfg)
                                                  : $urandom_range(1, hi);
            start_recv(lead, shift, 1'($urandom), edge_after, 8'($urandom), 1'($urandom),
                       (e == 2) ? $urandom_range(0, 2) - 1 : 0);
        end else if (kind < 95) begin
            start_send($urandom_range(0, 65535), shift, 8'($urandom), 1'($urandom));
            op_cap = 30;
        end else begin
            start_recv($urandom_range(0, 65535), shift, 1'($urandom), -1, 8'h00, 1'b0, 0);
            op_cap = 30;
        end
        if (kind >= 90 || $urandom_range(0, 6) == 0) begin
            run_ticks($urandom_range(1, (op_cap > OP_CAP_MAX) ? OP_CAP_MAX : op_cap), 1'b1);
            frame_on = 1'b0;
        end else begin
            finish_op();
        end
    endtask

    task automatic test_random_traffic();
        int target;
        int r;
        target = items_sent + RANDOM_TICKS;
        while (items_sent < target) begin
            r = $urandom_range(0, 9);
            set_config((r == 0) ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(2, 24)),
                       16'($urandom), 16'($urandom),
                       (r == 1) ? 16'($urandom) : 16'($urandom_range(0, 6) - 3));
            sender_idles = ($urandom_range(0, 3) != 0);
            rx_noise_pct = ($urandom_range(0, 3) == 0) ? 2 : 0;
            odd_cmd_pct  = $urandom_range(0, 5);
            repeat (2) random_op();
        end
        sender_idles = 1'b1;
        rx_noise_pct = 0;
        odd_cmd_pct  = 0;
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_lines.size() == 0) begin
                $error("result transaction with no tick outstanding");
                error_count++;
            end else begin
                want = expected_lines.pop_front();
                check_field("tx_level", 16'(want.tx_level), 16'(o_tx_level));
                check_field("tx_drive", 16'(want.tx_drive), 16'(o_tx_drive));
                check_field("done_res", 16'(want.done_res), 16'(o_done_res));
                check_field("status", 16'(want.status), 16'(o_status));
                check_field("rx_byte", 16'(want.rx_byte), 16'(o_rx_byte));
                check_field("rx_parity", 16'(want.rx_parity), 16'(o_rx_parity));
                check_field("time_stamp", want.time_stamp, o_time_stamp);
                checked_count++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(20, 120);
        end
        stall_left--;
        stall_beat++;
        case (stall_style)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= ($urandom_range(0, 99) >= 30);
            2:       i_out_ready <= (stall_beat % 5 != 0);
            default: i_out_ready <= ($urandom_range(0, 99) >= 75);
        endcase
    end

    initial begin
        reset_xcvr_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_send_frames();
        test_receive_frames();
        test_corner_cases();
        test_offset_extremes();
        test_random_traffic();
        settle();
        $display("%0d ticks driven, %0d result transactions checked, %0d register writes",
                 items_sent, checked_count, config_writes);
        $display("%0d frames sent, %0d frames received, %0d receive timeouts",
                 sends_done, recvs_done, timeouts_seen);
        if (error_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
